// ----- rtl/core/c8ie_pkg.sv -----
// ---------------------------------------------------------------------------
// c8ie_pkg: shared types and constants for the chip8 execute core
// Opcode group codes, ALU selectors, stack sizing and the execute result
// bundle passed from the execute unit to the state registers.
// ---------------------------------------------------------------------------
package c8ie_pkg;

  // architectural sizes
  localparam int STACK_DEPTH = 16;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int SLOT_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int ADDR_W      = 12;

  // opcode groups (bits 15..12)
  localparam logic [3:0] GRP_SYS   = 4'h0;
  localparam logic [3:0] GRP_JP    = 4'h1;
  localparam logic [3:0] GRP_CALL  = 4'h2;
  localparam logic [3:0] GRP_SE_K  = 4'h3;
  localparam logic [3:0] GRP_SNE_K = 4'h4;
  localparam logic [3:0] GRP_SE_V  = 4'h5;
  localparam logic [3:0] GRP_LD_K  = 4'h6;
  localparam logic [3:0] GRP_ADD_K = 4'h7;
  localparam logic [3:0] GRP_ALU   = 4'h8;
  localparam logic [3:0] GRP_SNE_V = 4'h9;
  localparam logic [3:0] GRP_LD_I  = 4'hA;
  localparam logic [3:0] GRP_JP_V0 = 4'hB;
  localparam logic [3:0] GRP_RND   = 4'hC;

  // full opcode of subroutine return
  localparam logic [15:0] OP_RET = 16'h00EE;

  // ALU selectors (bits 3..0 of group 8)
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // flag register number
  localparam logic [3:0] REG_VF = 4'hF;

  typedef logic [15:0][7:0] vfile_t;

  // execute result bundle
  typedef struct packed {
    logic [ADDR_W-1:0] pc;
    logic              idx_we;
    logic [ADDR_W-1:0] idx;
    logic              v_we;
    logic [3:0]        v_num;
    logic [7:0]        v_val;
    logic              f_we;
    logic [7:0]        f_val;
    logic [7:0]        vf_after;
    logic              push;
    logic              pop;
    logic              halt_set;
  } exec_t;

endpackage

// ----- rtl/core/c8ie_exec.sv -----
// ---------------------------------------------------------------------------
// c8ie_exec: single-pass instruction decode and execute
// Combinational: from one opcode and the current architectural state it
// works out the next pc, register writes, stack action and halt request.
// ---------------------------------------------------------------------------
module c8ie_exec
  import c8ie_pkg::*;
(
  input  logic [15:0]        opcode,
  input  logic [7:0]         random_byte,
  input  logic [ADDR_W-1:0]  pc,
  input  vfile_t             vregs,
  input  logic [ADDR_W-1:0]  stack_top,
  input  logic [LEVEL_W-1:0] level,
  input  logic               halt,
  output exec_t              res
);

  logic [3:0]        group;
  logic [3:0]        x;
  logic [3:0]        y;
  logic [3:0]        sel;
  logic [7:0]        kk;
  logic [ADDR_W-1:0] nnn;
  logic [7:0]        vx;
  logic [7:0]        vy;
  logic [ADDR_W-1:0] pc_inc;
  logic [ADDR_W-1:0] pc_skip;
  logic [8:0]        sum;

  // field split and operand read
  always_comb begin
    group   = opcode[15:12];
    x       = opcode[11:8];
    y       = opcode[7:4];
    sel     = opcode[3:0];
    kk      = opcode[7:0];
    nnn     = opcode[11:0];
    vx      = vregs[x];
    vy      = vregs[y];
    pc_inc  = pc + ADDR_W'(2);
    pc_skip = pc + ADDR_W'(4);
    sum     = {1'b0, vx} + {1'b0, vy};
  end

  // decode and execute
  always_comb begin
    res          = '0;
    res.pc       = pc;
    res.idx      = nnn;
    res.v_num    = x;
    if (!halt) begin
      res.pc = pc_inc;
      unique case (group)
        GRP_SYS: begin
          if (opcode == OP_RET) begin
            if (level != '0) begin
              res.pop = 1'b1;
              res.pc  = stack_top;
            end else begin
              res.halt_set = 1'b1;
            end
          end
        end
        GRP_JP: res.pc = nnn;
        GRP_CALL: begin
          if (level < LEVEL_W'(STACK_DEPTH)) begin
            res.push = 1'b1;
          end else begin
            res.halt_set = 1'b1;
          end
          res.pc = nnn;
        end
        GRP_SE_K:  if (vx == kk) res.pc = pc_skip;
        GRP_SNE_K: if (vx != kk) res.pc = pc_skip;
        GRP_SE_V:  if (vx == vy) res.pc = pc_skip;
        GRP_SNE_V: if (vx != vy) res.pc = pc_skip;
        GRP_LD_K: begin
          res.v_we  = 1'b1;
          res.v_val = kk;
        end
        GRP_ADD_K: begin
          res.v_we  = 1'b1;
          res.v_val = vx + kk;
        end
        GRP_ALU: begin
          unique case (sel)
            ALU_MOV: begin res.v_we = 1'b1; res.v_val = vy; end
            ALU_OR:  begin res.v_we = 1'b1; res.v_val = vx | vy; end
            ALU_AND: begin res.v_we = 1'b1; res.v_val = vx & vy; end
            ALU_XOR: begin res.v_we = 1'b1; res.v_val = vx ^ vy; end
            ALU_ADD: begin
              res.v_we  = 1'b1;
              res.v_val = sum[7:0];
              res.f_we  = 1'b1;
              res.f_val = {7'd0, sum[8]};
            end
            ALU_SUB: begin
              res.v_we  = 1'b1;
              res.v_val = vx - vy;
              res.f_we  = 1'b1;
              res.f_val = {7'd0, vx > vy};
            end
            ALU_SHR: begin
              res.v_we  = 1'b1;
              res.v_val = {1'b0, vx[7:1]};
              res.f_we  = 1'b1;
              res.f_val = {7'd0, vx[0]};
            end
            ALU_SUBN: begin
              res.v_we  = 1'b1;
              res.v_val = vy - vx;
              res.f_we  = 1'b1;
              res.f_val = {7'd0, vy > vx};
            end
            ALU_SHL: begin
              res.v_we  = 1'b1;
              res.v_val = {vx[6:0], 1'b0};
              res.f_we  = 1'b1;
              res.f_val = {7'd0, vx[7]};
            end
            default: ;
          endcase
        end
        GRP_LD_I:  res.idx_we = 1'b1;
        GRP_JP_V0: res.pc = nnn + {4'd0, vregs[0]};
        GRP_RND: begin
          res.v_we  = 1'b1;
          res.v_val = random_byte & kk;
        end
        default: ;
      endcase
    end

    // flag register after the writes, flag write last
    if (res.f_we) begin
      res.vf_after = res.f_val;
    end else if (res.v_we && (x == REG_VF)) begin
      res.vf_after = res.v_val;
    end else begin
      res.vf_after = vregs[REG_VF];
    end
  end

endmodule

// ----- rtl/core/chip8_instruction_execute_core.sv -----
// ---------------------------------------------------------------------------
// chip8_instruction_execute_core: chip8 interpreter execute core
// Executes one fetched opcode per item and reports the resulting state.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries an opcode and a random byte.
//   Output channel (out_valid / out_stall) carries next_pc, index_value,
//   the V register write (reg_written, reg_number, reg_value), VF and the
//   sticky halt flag for each item, one result per item, in order.
//   An accepted item is held in an input register, executes against the
//   architectural state (pc, index, V file, call stack) and lands in the
//   result register, which raises out_valid. Throughput is one item per
//   cycle while the receiver does not stall; the execute stage commits
//   state only when the result register is free or being taken.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_stall rises until the result is taken.
//   Reset clears pc, index, V registers, stack level, halt flag and both
//   valid bits. After a stack overflow or underflow the core halts: later
//   items still produce results that report the held state.
// ---------------------------------------------------------------------------
module chip8_instruction_execute_core
  import c8ie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] opcode,
  input  logic [7:0]  random_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] next_pc,
  output logic [11:0] index_value,
  output logic        reg_written,
  output logic [3:0]  reg_number,
  output logic [7:0]  reg_value,
  output logic [7:0]  flag_value,
  output logic        halted
);

  // input register
  logic        hold_valid;
  logic [15:0] hold_op;
  logic [7:0]  hold_rnd;

  // architectural state
  logic [ADDR_W-1:0]  pc;
  logic [ADDR_W-1:0]  index_reg;
  vfile_t             vregs;
  logic [ADDR_W-1:0]  stack [STACK_DEPTH];
  logic [LEVEL_W-1:0] level;
  logic               halt;

  logic               advance;
  logic               accept;
  logic               fire;
  logic [LEVEL_W-1:0] level_dec;
  logic [SLOT_W-1:0]  pop_slot;
  logic [SLOT_W-1:0]  push_slot;
  exec_t              res;

  // handshake
  assign advance  = !out_valid || !out_stall;
  assign in_stall = hold_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign fire     = hold_valid && advance;

  // stack slots
  assign level_dec = level - LEVEL_W'(1);
  assign pop_slot  = level_dec[SLOT_W-1:0];
  assign push_slot = level[SLOT_W-1:0];

  c8ie_exec u_exec (
    .opcode      (hold_op),
    .random_byte (hold_rnd),
    .pc          (pc),
    .vregs       (vregs),
    .stack_top   (stack[pop_slot]),
    .level       (level),
    .halt        (halt),
    .res         (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= accept || (hold_valid && !advance);
    end
    if (accept) begin
      hold_op  <= opcode;
      hold_rnd <= random_byte;
    end
  end

  // architectural state commit
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      index_reg <= '0;
      vregs     <= '0;
      level     <= '0;
      halt      <= 1'b0;
    end else if (fire) begin
      pc <= res.pc;
      if (res.idx_we) index_reg <= res.idx;
      if (res.v_we) vregs[res.v_num] <= res.v_val;
      if (res.f_we) vregs[REG_VF] <= res.f_val;
      if (res.push) begin
        level <= level + LEVEL_W'(1);
      end else if (res.pop) begin
        level <= level_dec;
      end
      if (res.halt_set) halt <= 1'b1;
    end
  end

  // call stack, only read after written
  always_ff @(posedge clk) begin
    if (fire && res.push) begin
      stack[push_slot] <= pc + ADDR_W'(2);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
    if (fire) begin
      next_pc     <= res.pc;
      index_value <= res.idx_we ? res.idx : index_reg;
      reg_written <= res.v_we;
      reg_number  <= res.v_we ? res.v_num : 4'd0;
      reg_value   <= res.v_we ? res.v_val : 8'd0;
      flag_value  <= res.vf_after;
      halted      <= halt || res.halt_set;
    end
  end

endmodule

// ----- tb/chip8_instruction_execute_core_test.sv -----
// ---------------------------------------------------------------------------
// chip8_instruction_execute_core_test: self-checking bench for the execute core
// Streams fetched opcodes into the core and predicts pc, index, the V register
// write, VF and the halt flag for every item. Each result is checked in order
// against the prediction. A directed opening pass comes first, then random
// register, ALU, skip and call/return traffic, and finally a stack overflow
// or underflow that halts the core. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chip8_instruction_execute_core_test
  import c8ie_pkg::*;
();

  // opcode groups the core treats as no-ops
  localparam logic [3:0]  GRP_DRAW    = 4'hD;
  localparam logic [3:0]  GRP_KEY     = 4'hE;
  localparam logic [3:0]  GRP_MISC    = 4'hF;
  localparam logic [15:0] OP_CLS      = 16'h00E0;
  // ALU selectors with no operation behind them
  localparam logic [3:0]  ALU_NONE_LO = 4'h8;
  localparam logic [3:0]  ALU_NONE_HI = 4'hF;
  localparam int          QUIET_LIMIT = 1000;
  localparam int          RANDOM_OPS  = 800;

  typedef struct packed {
    logic [15:0] op;
    logic [7:0]  rnd;
  } fetch_t;

  typedef struct packed {
    logic [11:0] pc;
    logic [11:0] idx;
    logic        wr;
    logic [3:0]  num;
    logic [7:0]  val;
    logic [7:0]  vf;
    logic        halt;
  } core_view_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] opcode = 16'h0000;
  logic [7:0]  random_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] next_pc;
  logic [11:0] index_value;
  logic        reg_written;
  logic [3:0]  reg_number;
  logic [7:0]  reg_value;
  logic [7:0]  flag_value;
  logic        halted;

  // architectural state as predicted
  logic [11:0] arch_pc = '0;
  logic [11:0] arch_index = '0;
  logic [7:0]  arch_v [16];
  logic [11:0] arch_stack [STACK_DEPTH];
  int          stack_used = 0;
  int          stack_peak = 0;
  bit          arch_halt = 1'b0;

  fetch_t     fetch_queue [$];
  core_view_t expected_states [$];
  fetch_t     next_fetch;
  core_view_t observed_state;
  core_view_t wanted_state;

  int gen_level = 0;
  int total_items = 0;
  int accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int calls_done = 0;
  int returns_done = 0;
  int skips_taken = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;
  bit overflow_end;

  chip8_instruction_execute_core uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .random_byte (random_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .next_pc     (next_pc),
    .index_value (index_value),
    .reg_written (reg_written),
    .reg_number  (reg_number),
    .reg_value   (reg_value),
    .flag_value  (flag_value),
    .halted      (halted)
  );

  always #1 clk = ~clk;

  // gap length: mostly none, some short, a few long
  function automatic int idle_cycles(input bit steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // byte values that make compares and carries likely
  function automatic logic [7:0] corner_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7F;
      3: return 8'h80;
      4: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // queue one item and track the stack depth it will leave behind
  task automatic push_item(input logic [15:0] op, input logic [7:0] rnd);
    fetch_queue.push_back({op, rnd});
    total_items++;
    if (op[15:12] == GRP_CALL) gen_level++;
    else if (op == OP_RET) gen_level--;
  endtask

  // random opcode that keeps the stack inside its limits
  task automatic add_random_item();
    logic [3:0]  grp;
    logic [3:0]  x;
    logic [7:0]  kk;
    logic [15:0] op;
    grp = 4'($urandom_range(0, 15));
    x = 4'($urandom);
    kk = $urandom_range(0, 1) ? corner_byte() : 8'($urandom);
    op = {grp, x, kk};
    case (grp)
      GRP_SYS: begin
        if (gen_level > 0 && $urandom_range(0, 3) != 0) op = OP_RET;
        else if (op == OP_RET || $urandom_range(0, 7) == 0) op = OP_CLS;
      end
      GRP_CALL: begin
        if (gen_level >= STACK_DEPTH) op[15:12] = GRP_JP;
      end
      GRP_SE_V, GRP_SNE_V: begin
        if ($urandom_range(0, 2) == 0) op[7:4] = x;
      end
      GRP_ALU: begin
        if ($urandom_range(0, 7) != 0) begin
          op[3:0] = 4'($urandom_range(0, 7));
          if ($urandom_range(0, 8) == 0) op[3:0] = ALU_SHL;
        end
      end
      default: ;
    endcase
    push_item(op, 8'($urandom));
  endtask

  // execute one opcode on the predicted state and queue the expected result
  task automatic execute_opcode(input logic [15:0] op, input logic [7:0] rnd);
    logic [3:0]  grp;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [11:0] pc;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [8:0]  sum;
    logic [7:0]  wval;
    logic [7:0]  fval;
    logic        wrote;
    logic        set_flag;
    core_view_t  view;
    grp = op[15:12];
    x = op[11:8];
    y = op[7:4];
    kk = op[7:0];
    nnn = op[11:0];
    wrote = 1'b0;
    set_flag = 1'b0;
    wval = '0;
    fval = '0;
    if (!arch_halt) begin
      pc = arch_pc + 12'd2;
      vx = arch_v[x];
      vy = arch_v[y];
      case (grp)
        GRP_SYS: begin
          if (op == OP_RET) begin
            if (stack_used > 0) begin
              stack_used--;
              pc = arch_stack[SLOT_W'(stack_used)];
              returns_done++;
            end else begin
              arch_halt = 1'b1;
            end
          end
        end
        GRP_JP: pc = nnn;
        GRP_CALL: begin
          // a full stack halts but the jump still happens
          if (stack_used < STACK_DEPTH) begin
            arch_stack[SLOT_W'(stack_used)] = pc;
            stack_used++;
            calls_done++;
            if (stack_used > stack_peak) stack_peak = stack_used;
          end else begin
            arch_halt = 1'b1;
          end
          pc = nnn;
        end
        GRP_SE_K: if (vx == kk) begin pc = pc + 12'd2; skips_taken++; end
        GRP_SNE_K: if (vx != kk) begin pc = pc + 12'd2; skips_taken++; end
        GRP_SE_V: if (vx == vy) begin pc = pc + 12'd2; skips_taken++; end
        GRP_SNE_V: if (vx != vy) begin pc = pc + 12'd2; skips_taken++; end
        GRP_LD_K: begin wrote = 1'b1; wval = kk; end
        GRP_ADD_K: begin wrote = 1'b1; wval = vx + kk; end
        GRP_ALU: begin
          case (op[3:0])
            ALU_MOV: begin wrote = 1'b1; wval = vy; end
            ALU_OR:  begin wrote = 1'b1; wval = vx | vy; end
            ALU_AND: begin wrote = 1'b1; wval = vx & vy; end
            ALU_XOR: begin wrote = 1'b1; wval = vx ^ vy; end
            ALU_ADD: begin
              sum = {1'b0, vx} + {1'b0, vy};
              wrote = 1'b1; set_flag = 1'b1;
              wval = sum[7:0];
              fval = {7'd0, sum[8]};
            end
            ALU_SUB: begin
              wrote = 1'b1; set_flag = 1'b1;
              wval = vx - vy;
              fval = {7'd0, vx > vy};
            end
            ALU_SHR: begin
              wrote = 1'b1; set_flag = 1'b1;
              wval = vx >> 1;
              fval = {7'd0, vx[0]};
            end
            ALU_SUBN: begin
              wrote = 1'b1; set_flag = 1'b1;
              wval = vy - vx;
              fval = {7'd0, vy > vx};
            end
            ALU_SHL: begin
              wrote = 1'b1; set_flag = 1'b1;
              wval = {vx[6:0], 1'b0};
              fval = {7'd0, vx[7]};
            end
            default: ;
          endcase
        end
        GRP_LD_I: arch_index = nnn;
        GRP_JP_V0: pc = nnn + {4'h0, arch_v[0]};
        GRP_RND: begin wrote = 1'b1; wval = rnd & kk; end
        default: ;
      endcase
      // flag goes in after vx so it wins when x is VF
      if (wrote) arch_v[x] = wval;
      if (set_flag) arch_v[REG_VF] = fval;
      arch_pc = pc;
    end
    view.pc = arch_pc;
    view.idx = arch_index;
    view.wr = wrote;
    view.num = wrote ? x : 4'h0;
    view.val = wrote ? wval : 8'h00;
    view.vf = arch_v[REG_VF];
    view.halt = arch_halt;
    expected_states.push_back(view);
  endtask

  // driver: offer queued items, predict each one as it is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        execute_opcode(opcode, random_byte);
        accepted++;
        if (accepted % 50 == 0) steady_in = ($urandom_range(0, 3) == 0);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (fetch_queue.size() > 0) begin
          next_fetch = fetch_queue.pop_front();
          opcode <= next_fetch.op;
          random_byte <= next_fetch.rnd;
          in_valid <= 1'b1;
          gap_left = idle_cycles(steady_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result against the oldest prediction, drive stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        observed_state = {next_pc, index_value, reg_written, reg_number, reg_value,
                          flag_value, halted};
        results_seen++;
        if (expected_states.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          wanted_state = expected_states.pop_front();
          if (observed_state !== wanted_state) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d mismatch: got pc=%h i=%h wr=%b v%h=%h vf=%h halt=%b",
                       results_seen, observed_state.pc, observed_state.idx,
                       observed_state.wr, observed_state.num, observed_state.val,
                       observed_state.vf, observed_state.halt);
              $display("  expected           pc=%h i=%h wr=%b v%h=%h vf=%h halt=%b",
                       wanted_state.pc, wanted_state.idx, wanted_state.wr,
                       wanted_state.num, wanted_state.val, wanted_state.vf,
                       wanted_state.halt);
            end
          end
        end
        if (results_seen % 50 == 0) steady_out = ($urandom_range(0, 3) == 0);
        // long hold so the core backs up into its input
        if (results_seen % 300 == 150) hold_left = 100;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = idle_cycles(steady_out);
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no item moved for %0d cycles", QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    arch_v = '{default: 8'h00};
    arch_stack = '{default: 12'h000};

    // load, add with wrap, carry and borrow flags
    push_item({GRP_LD_K, 4'h0, 8'hFF}, 8'h00);
    push_item({GRP_ADD_K, 4'h0, 8'h01}, 8'hFF);
    push_item({GRP_LD_K, 4'hA, 8'hFF}, 8'h00);
    push_item({GRP_LD_K, 4'hB, 8'h01}, 8'h00);
    push_item({GRP_ALU, 4'hA, 4'hB, ALU_ADD}, 8'h00);
    push_item({GRP_ALU, 4'hA, 4'hB, ALU_SUB}, 8'h00);
    push_item({GRP_ALU, 4'hA, 4'hB, ALU_SUBN}, 8'h00);
    push_item({GRP_LD_K, 4'hA, 8'h81}, 8'h00);
    push_item({GRP_ALU, 4'hA, 4'hB, ALU_SHL}, 8'h00);
    // shift into VF itself: the flag overwrites the shifted value
    push_item({GRP_LD_K, REG_VF, 8'h81}, 8'h00);
    push_item({GRP_ALU, REG_VF, 4'h0, ALU_SHR}, 8'h00);
    push_item({GRP_ALU, 4'hA, 4'hB, ALU_MOV}, 8'h00);
    push_item({GRP_ALU, 4'hA, 4'hB, ALU_OR}, 8'h00);
    push_item({GRP_ALU, 4'hA, 4'hB, ALU_AND}, 8'h00);
    push_item({GRP_ALU, 4'hA, 4'hB, ALU_XOR}, 8'h00);
    push_item({GRP_ALU, 4'hA, 4'hB, ALU_NONE_LO}, 8'h00);
    push_item({GRP_ALU, 4'hA, 4'hB, ALU_NONE_HI}, 8'h00);
    // skips, with junk in the low nibble of the register compares
    push_item({GRP_SE_K, 4'hB, 8'h01}, 8'h00);
    push_item({GRP_SNE_K, 4'hB, 8'h01}, 8'h00);
    push_item({GRP_SE_V, 4'hA, 4'hB, 4'h7}, 8'h00);
    push_item({GRP_SNE_V, 4'hA, 4'hB, 4'hC}, 8'h00);
    // index, jump through V0 with wrap, random masks
    push_item({GRP_LD_I, 12'hFFF}, 8'h00);
    push_item({GRP_LD_K, 4'h0, 8'h10}, 8'h00);
    push_item({GRP_JP_V0, 12'hFFF}, 8'h00);
    push_item({GRP_RND, 4'h5, 8'hAA}, 8'hFF);
    push_item({GRP_RND, 4'h6, 8'hFF}, 8'h00);
    // pc wraps past the top, call and return, ignored groups
    push_item({GRP_JP, 12'hFFE}, 8'h00);
    push_item(OP_CLS, 8'h00);
    push_item({GRP_CALL, 12'hABC}, 8'h00);
    push_item(OP_RET, 8'h00);
    push_item({GRP_SYS, 12'h123}, 8'h00);
    push_item({GRP_DRAW, 12'h123}, 8'h00);
    push_item({GRP_KEY, 12'h19E}, 8'h00);
    push_item({GRP_MISC, 12'h107}, 8'h00);

    for (int i = 0; i < RANDOM_OPS; i++) add_random_item();

    // the halt is sticky, so only one of the two stack faults per run
    overflow_end = 1'($urandom_range(0, 1));
    if (overflow_end) begin
      while (gen_level < STACK_DEPTH) push_item({GRP_CALL, 12'($urandom)}, 8'($urandom));
      push_item({GRP_CALL, 12'($urandom)}, 8'($urandom));
    end else begin
      while (gen_level > 0) push_item(OP_RET, 8'($urandom));
      push_item(OP_RET, 8'($urandom));
    end
    for (int i = 0; i < 6; i++) add_random_item();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (accepted < total_items || expected_states.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d opcodes: %0d calls, %0d returns, %0d skips taken, stack peak %0d of %0d",
             accepted, calls_done, returns_done, skips_taken, stack_peak, STACK_DEPTH);
    $display("closing stack %s left the core %s", overflow_end ? "overflow" : "underflow",
             arch_halt ? "halted" : "running");
    if (mismatches == 0 && expected_states.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
